### rtl/iot_pkg.sv
// ----------------------------------------------------------------------------
// iot_pkg
// Shared types and constants for the interval overlay table.
// ----------------------------------------------------------------------------
`default_nettype none

package iot_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int HEAP_BITS   = 4;
   localparam int OWNER_BITS  = 16;

   // stored widths: the ports carry 4 heap bits and 16 owner bits
   localparam int HEAP_W = (HEAP_BITS < 4) ? HEAP_BITS : 4;
   localparam int OWN_W  = (OWNER_BITS < 16) ? OWNER_BITS : 16;
   localparam int ADDR_W = 33;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WR_W   = $clog2(TABLE_DEPTH + 3);

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_STOPPED = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } iot_status_type;

   typedef enum logic [1:0] {
      WS_ENT  = 2'd0,   // current entry as read
      WS_HEAD = 2'd1,   // current entry cut to end at the new start
      WS_TAIL = 2'd2,   // current entry cut to start at the new end
      WS_NEW  = 2'd3    // the new range
   } iot_wsrc_type;

   typedef enum logic [1:0] {
      CM_PLACE = 2'd0,
      CM_STOP  = 2'd1,
      CM_CLEAR = 2'd2
   } iot_commit_type;

   typedef struct packed {
      logic [ADDR_W-1:0] rng_start;
      logic [ADDR_W-1:0] rng_end;
      logic [HEAP_W-1:0] heap;
      logic [OWN_W-1:0]  owner;
   } iot_entry_type;

   typedef struct packed {
      logic           start;
      logic           rd_en;
      logic           wr_en;
      iot_wsrc_type   wr_src;
      logic           push;
      logic           commit;
      iot_commit_type commit_kind;
      logic           out_rd;
      logic           out_next;
   } iot_cmd_type;

   typedef struct packed {
      logic rd_done;
      logic heap_match;
      logic own_match;
      logic b_le_start;
      logic end_le_a;
      logic a_le_start;
      logic end_le_b;
      logic b_lt_end;
      logic out_last;
   } iot_stat_type;

endpackage

`default_nettype wire

### rtl/iot_ctrl.sv
// ----------------------------------------------------------------------------
// iot_ctrl
// Sequencer: walks the old table one entry at a time and issues writes of
// the rebuilt table, then commits and hands out the result items.
// ----------------------------------------------------------------------------
`default_nettype none

module iot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  iot_pkg::iot_stat_type stat,
   output iot_pkg::iot_cmd_type  cmd
);
   import iot_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_FETCH    = 9'b000000010,
      S_EVAL     = 9'b000000100,
      S_W_ENT    = 9'b000001000,
      S_W_NEW    = 9'b000010000,
      S_W_TAIL   = 9'b000100000,
      S_COMMIT   = 9'b001000000,
      S_OUT_RD   = 9'b010000000,
      S_OUT_WAIT = 9'b100000000
   } iot_state_type;

   iot_state_type state_ff, state_in;
   logic clear_ff, clear_in;
   logic walk_ff, walk_in;   // inside the heap's run of entries
   logic rest_ff, rest_in;   // placement settled, copy the remainder
   logic stop_ff, stop_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic walk_now;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign walk_now  = walk_ff | (~rest_ff & stat.heap_match);

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      walk_in      = walk_ff;
      rest_in      = rest_ff;
      stop_in      = stop_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.wr_src   = WS_ENT;
      cmd.commit_kind = clear_ff ? CM_CLEAR : (stop_ff ? CM_STOP : CM_PLACE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               clear_in  = req_cmd;
               walk_in   = 1'b0;
               rest_in   = 1'b0;
               stop_in   = 1'b0;
               state_in  = req_cmd ? S_COMMIT : S_FETCH;
            end
         end
         S_FETCH: begin
            if (stat.rd_done) begin
               // heap absent or walk ran off the end: new range goes last
               cmd.wr_en  = ~rest_ff;
               cmd.wr_src = WS_NEW;
               state_in   = S_COMMIT;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_FETCH;
            if (rest_ff || !walk_now) begin
               cmd.wr_en = 1'b1;
            end else begin
               walk_in = 1'b1;
               priority if (stat.own_match) begin
                  cmd.wr_en = 1'b1;
                  rest_in   = 1'b1;
                  stop_in   = 1'b1;
               end else if (!stat.heap_match || stat.b_le_start) begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_src = WS_NEW;
                  rest_in    = 1'b1;
                  state_in   = S_W_ENT;
               end else if (stat.end_le_a) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.push = 1'b1;
                  priority if (stat.a_le_start && stat.end_le_b) begin
                     // fully covered: dropped
                  end else if (stat.a_le_start) begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_src = WS_NEW;
                     rest_in    = 1'b1;
                     state_in   = S_W_TAIL;
                  end else if (stat.b_lt_end) begin
                     // split around the new range
                     cmd.wr_en  = 1'b1;
                     cmd.wr_src = WS_HEAD;
                     rest_in    = 1'b1;
                     state_in   = S_W_NEW;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_src = WS_HEAD;
                  end
               end
            end
         end
         S_W_ENT: begin
            cmd.wr_en = 1'b1;
            state_in  = S_FETCH;
         end
         S_W_NEW: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WS_NEW;
            state_in   = S_W_TAIL;
         end
         S_W_TAIL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WS_TAIL;
            state_in   = S_FETCH;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT_RD;
         end
         S_OUT_RD: begin
            cmd.out_rd   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clear_ff     <= 1'b0;
         walk_ff      <= 1'b0;
         rest_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         walk_ff      <= walk_in;
         rest_ff      <= rest_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/iot_dp.sv
// ----------------------------------------------------------------------------
// iot_dp
// Datapath: two table banks (old is read, new is written, swapped on a
// commit that fits), range compares, overlapped-owner queue and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module iot_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  iot_pkg::iot_cmd_type  cmd,
   output iot_pkg::iot_stat_type stat,
   input  logic [3:0]            req_heap_id,
   input  logic [31:0]           req_range_offset,
   input  logic [31:0]           req_range_size,
   input  logic [15:0]           req_owner_id,
   output logic [1:0]            rsp_status,
   output logic                  rsp_has_overlap,
   output logic [15:0]           rsp_overlapped_owner,
   output logic                  rsp_last
);
   import iot_pkg::*;

   iot_entry_type  tbl_mem [2**(IDX_W+1)];
   logic [OWN_W-1:0] ovl_mem [2**IDX_W];

   logic [ADDR_W-1:0] a_ff, b_ff;
   logic [HEAP_W-1:0] heap_ff;
   logic [OWN_W-1:0]  own_ff;
   logic              bank_ff;
   logic [CNT_W-1:0]  count_ff, rd_idx_ff, nov_ff, k_ff;
   logic [WR_W-1:0]   wr_idx_ff;
   iot_status_type    status_ff;
   iot_entry_type     rd_q_ff;
   logic [OWN_W-1:0]  ovl_q_ff;

   iot_entry_type wdata;
   logic          full;
   logic          wr_fits;

   assign full    = (wr_idx_ff > WR_W'(TABLE_DEPTH));
   assign wr_fits = (wr_idx_ff < WR_W'(TABLE_DEPTH));

   always_comb begin
      wdata = rd_q_ff;
      unique case (cmd.wr_src)
         WS_ENT:  wdata = rd_q_ff;
         WS_HEAD: wdata.rng_end = a_ff;
         WS_TAIL: wdata.rng_start = b_ff;
         WS_NEW: begin
            wdata.rng_start = a_ff;
            wdata.rng_end   = b_ff;
            wdata.heap      = heap_ff;
            wdata.owner     = own_ff;
         end
         default: wdata = rd_q_ff;
      endcase
   end

   assign stat.rd_done    = (rd_idx_ff == count_ff);
   assign stat.heap_match = (rd_q_ff.heap == heap_ff);
   assign stat.own_match  = (rd_q_ff.owner == own_ff);
   assign stat.b_le_start = (b_ff <= rd_q_ff.rng_start);
   assign stat.end_le_a   = (rd_q_ff.rng_end <= a_ff);
   assign stat.a_le_start = (a_ff <= rd_q_ff.rng_start);
   assign stat.end_le_b   = (rd_q_ff.rng_end <= b_ff);
   assign stat.b_lt_end   = (b_ff < rd_q_ff.rng_end);
   assign stat.out_last   = (nov_ff == '0) || ((CNT_W+1)'(k_ff) + 1'b1 == (CNT_W+1)'(nov_ff));

   assign rsp_status           = status_ff;
   assign rsp_has_overlap      = (nov_ff != '0);
   assign rsp_overlapped_owner = rsp_has_overlap ? 16'(ovl_q_ff) : 16'd0;
   assign rsp_last             = stat.out_last;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_q_ff <= tbl_mem[{bank_ff, rd_idx_ff[IDX_W-1:0]}];
      end
      if (cmd.wr_en && wr_fits) begin
         tbl_mem[{~bank_ff, wr_idx_ff[IDX_W-1:0]}] <= wdata;
      end
      if (cmd.push) begin
         ovl_mem[nov_ff[IDX_W-1:0]] <= rd_q_ff.owner;
      end
      if (cmd.out_rd) begin
         ovl_q_ff <= ovl_mem[k_ff[IDX_W-1:0]];
      end
   end

   // command fields
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff    <= {1'b0, req_range_offset};
         b_ff    <= {1'b0, req_range_offset} + {1'b0, req_range_size};
         heap_ff <= req_heap_id[HEAP_W-1:0];
         own_ff  <= req_owner_id[OWN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         count_ff  <= '0;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         nov_ff    <= '0;
         k_ff      <= '0;
         status_ff <= ST_PLACED;
      end else begin
         if (cmd.start) begin
            rd_idx_ff <= '0;
            wr_idx_ff <= '0;
            nov_ff    <= '0;
            k_ff      <= '0;
         end
         if (cmd.rd_en) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (cmd.wr_en) begin
            wr_idx_ff <= wr_idx_ff + 1'b1;
         end
         if (cmd.push) begin
            nov_ff <= nov_ff + 1'b1;
         end
         if (cmd.out_next) begin
            k_ff <= k_ff + 1'b1;
         end
         if (cmd.commit) begin
            unique case (cmd.commit_kind)
               CM_CLEAR: begin
                  count_ff  <= '0;
                  nov_ff    <= '0;
                  status_ff <= ST_CLEARED;
               end
               CM_PLACE, CM_STOP: begin
                  if (full) begin
                     nov_ff    <= '0;
                     status_ff <= ST_FULL;
                  end else begin
                     bank_ff   <= ~bank_ff;
                     count_ff  <= wr_idx_ff[CNT_W-1:0];
                     status_ff <= (cmd.commit_kind == CM_STOP) ? ST_STOPPED : ST_PLACED;
                  end
               end
               default: begin
                  status_ff <= status_ff;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### rtl/interval_overlay_table_core.sv
// ----------------------------------------------------------------------------
// interval_overlay_table_core
// Table of owned address ranges per heap; placement overwrites overlaps.
// ----------------------------------------------------------------------------
//  channel | prefix | handshake         | payload
//  request | req_   | req_valid/ready   | cmd, heap_id, range_offset, size, owner_id
//  result  | rsp_   | rsp_valid/ready   | status, has_overlap, overlapped_owner, last
//
//  One item at a time. A place reads each stored entry in turn and writes
//  the rebuilt table to the other bank; an insert before an entry or a
//  trimmed tail adds one write, a split adds two. Then it settles, commits
//  and reads out each result item; the single read port of the table memory
//  sets the pace. A clear skips the walk. Reset empties the table at once
//  (count register). req_ready is low while an item is in work or pending.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_overlay_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [3:0]  req_heap_id,
   input  logic [31:0] req_range_offset,
   input  logic [31:0] req_range_size,
   input  logic [15:0] req_owner_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_has_overlap,
   output logic [15:0] rsp_overlapped_owner,
   output logic        rsp_last
);
   import iot_pkg::*;

   iot_cmd_type  cmd;
   iot_stat_type stat;

   iot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   iot_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_heap_id          (req_heap_id),
      .req_range_offset     (req_range_offset),
      .req_range_size       (req_range_size),
      .req_owner_id         (req_owner_id),
      .rsp_status           (rsp_status),
      .rsp_has_overlap      (rsp_has_overlap),
      .rsp_overlapped_owner (rsp_overlapped_owner),
      .rsp_last             (rsp_last)
   );

`ifndef SYNTH
   a_no_overlap_in_out: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_multi_needs_overlap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> rsp_has_overlap)
      else $error("non-final item without an overlapped owner");

   a_single_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_CLEARED))
      |-> (!rsp_has_overlap && rsp_last))
      else $error("full or clear result must be a single plain item");
`endif

endmodule

`default_nettype wire

### dv/tb_interval_overlay_table_core.sv
// ----------------------------------------------------------------------------
// tb_interval_overlay_table_core
// Self-checking bench for the interval overlay table: directed placements,
// splits, same-owner stops, table full and clear, then random traffic
// checked against a behavioral table model under varied handshake idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_interval_overlay_table_core;
   import iot_pkg::*;

   localparam int DEPTH = iot_pkg::TABLE_DEPTH;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [1:0]  status;
      logic        has_ovl;
      logic [15:0] owner;
      logic        last;
   } result_type;

   typedef struct {
      logic        cmd;
      logic [3:0]  heap;
      logic [31:0] offset;
      logic [31:0] size;
      logic [15:0] owner;
      logic        fixed;     // expected status typed in
      logic [1:0]  fixed_status;
   } stim_type;

   logic        clock, reset;
   logic        req_valid, req_ready, req_cmd;
   logic [3:0]  req_heap_id;
   logic [31:0] req_range_offset, req_range_size;
   logic [15:0] req_owner_id;
   logic        rsp_valid, rsp_ready, rsp_has_overlap, rsp_last;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_overlapped_owner;

   interval_overlay_table_core dut (.*);

   // table model
   logic [32:0] tbl_start[$], tbl_end[$];
   logic [3:0]  tbl_heap[$];
   logic [15:0] tbl_owner[$];
   result_type  pending_results[$];

   int  failures = 0;
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  hold_rsp = 0;
   bit  stim_done = 0;
   int  idle_cycles = 0;

   function automatic void predict_place(logic cmd, logic [3:0] heap, logic [31:0] offs,
                                         logic [31:0] size, logic [15:0] own);
      logic [32:0] ws[$], we[$];
      logic [3:0]  wh[$];
      logic [15:0] wo[$], ovl[$];
      logic [32:0] a, b;
      logic [1:0]  st;
      int i, first, ins;
      bit found, stopped;
      result_type r;
      if (cmd) begin
         tbl_start.delete(); tbl_end.delete(); tbl_heap.delete(); tbl_owner.delete();
         r = '{ST_CLEARED, 1'b0, 16'd0, 1'b1};
         pending_results.push_back(r);
         return;
      end
      a = {1'b0, offs};
      b = a + {1'b0, size};
      ws = tbl_start; we = tbl_end; wh = tbl_heap; wo = tbl_owner;
      found = 0; first = 0;
      foreach (wh[k]) if (!found && wh[k] == heap) begin found = 1; first = k; end
      st = ST_PLACED; stopped = 0;
      if (!found) begin
         ws.push_back(a); we.push_back(b); wh.push_back(heap); wo.push_back(own);
      end else begin
         i = first; ins = first;
         while (i < ws.size()) begin
            if (wo[i] == own) begin st = ST_STOPPED; stopped = 1; break; end
            if (wh[i] != heap || b <= ws[i]) begin ins = i; break; end
            if (we[i] <= a) begin i++; ins = i; continue; end
            ovl.push_back(wo[i]);
            if (a <= ws[i]) begin
               if (we[i] <= b) begin
                  ws.delete(i); we.delete(i); wh.delete(i); wo.delete(i);
                  ins = i;
               end else begin
                  ws[i] = b; ins = i; break;
               end
            end else if (b < we[i]) begin
               // new range falls inside: split around it
               ws.insert(i + 1, b); we.insert(i + 1, we[i]);
               wh.insert(i + 1, wh[i]); wo.insert(i + 1, wo[i]);
               we[i] = a; ins = i + 1; break;
            end else begin
               we[i] = a; i++; ins = i;
            end
         end
         if (!stopped) begin
            ws.insert(ins, a); we.insert(ins, b); wh.insert(ins, heap); wo.insert(ins, own);
         end
      end
      if (ws.size() > DEPTH) begin
         r = '{ST_FULL, 1'b0, 16'd0, 1'b1};
         pending_results.push_back(r);
         return;
      end
      tbl_start = ws; tbl_end = we; tbl_heap = wh; tbl_owner = wo;
      if (ovl.size() == 0) begin
         r = '{st, 1'b0, 16'd0, 1'b1};
         pending_results.push_back(r);
      end else
         foreach (ovl[k]) begin
            r = '{st, 1'b1, ovl[k], k == ovl.size() - 1};
            pending_results.push_back(r);
         end
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(stim_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= s.cmd;
      req_heap_id      <= s.heap;
      req_range_offset <= s.offset;
      req_range_size   <= s.size;
      req_owner_id     <= s.owner;
      do @(posedge clock); while (!req_ready);
      predict_place(s.cmd, s.heap, s.offset, s.size, s.owner);
      if (s.fixed && pending_results[$].status != s.fixed_status) begin
         $error("directed status: expected %0d predicted %0d", s.fixed_status,
                pending_results[$].status);
         failures++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic stim_type mk(logic cmd, logic [3:0] h, logic [31:0] o, logic [31:0] s,
                                   logic [15:0] w, logic f = 0, logic [1:0] fs = ST_PLACED);
      stim_type t;
      t = '{cmd, h, o, s, w, f, fs};
      return t;
   endfunction

   // random place, mostly in a small window so ranges collide often, with some wide items and clears
   function automatic stim_type rand_place();
      stim_type t;
      int pick;
      pick = $urandom_range(99);
      t = mk(1'b0, 4'($urandom_range(2)), $urandom_range(200), $urandom_range(60),
             16'($urandom_range(40)));
      if (pick < 6) begin
         t.offset = $urandom; t.size = $urandom;
         t.heap = 4'($urandom); t.owner = 16'($urandom);
      end else if (pick < 9)
         t.cmd = 1'b1;
      return t;
   endfunction

   stim_type directed[$];

   initial begin
      req_valid = 0; req_cmd = 0; req_heap_id = 0; req_range_offset = 0;
      req_range_size = 0; req_owner_id = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed = '{
         mk(1'b0, 4'd0, 32'd100, 32'd50, 16'd1, 1'b1, ST_PLACED),   // empty heap
         mk(1'b0, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_PLACED),
         mk(1'b0, 4'd0, 32'd120, 32'd0, 16'd2),                     // zero size split
         mk(1'b0, 4'd0, 32'd110, 32'd20, 16'd3),
         mk(1'b0, 4'd0, 32'd90, 32'd100, 16'd4),                    // covers several
         mk(1'b0, 4'd0, 32'd0, 32'd10, 16'd5),
         mk(1'b0, 4'd0, 32'd5, 32'd200, 16'd4),                     // same owner met
         mk(1'b0, 4'd15, 32'd0, 32'd1, 16'hFFFF),                   // stops on match
         mk(1'b0, 4'd7, 32'd0, 32'hFFFF_FFFF, 16'd0),
         mk(1'b1, 4'd9, 32'hFFFF_FFFF, 32'd3, 16'd7, 1'b1, ST_CLEARED),
         mk(1'b0, 4'd0, 32'd0, 32'd0, 16'd0, 1'b1, ST_PLACED)
      };
      // one heap of separate ranges, then one range over all of them
      for (int k = 0; k < 14; k++)
         directed.push_back(mk(1'b0, 4'd1, 32'd1000 - 32'(40 * k), 32'd30,
                               16'(100 + k)));
      directed.push_back(mk(1'b0, 4'd1, 32'd0, 32'd2000, 16'd500));
      // fill the table to the last entry
      for (int k = 0; k < 30; k++)
         directed.push_back(mk(1'b0, 4'd3, 32'(10 * k), 32'd5, 16'(600 + k)));
      // split needs two more entries: table full
      directed.push_back(mk(1'b0, 4'd1, 32'd50, 32'd1, 16'd900, 1'b1, ST_FULL));
      directed.push_back(mk(1'b1, 4'd0, 32'd0, 32'd0, 16'd0, 1'b1, ST_CLEARED));

      foreach (directed[k]) send_item(directed[k]);
      drain();

      send_idle_pct = 13; recv_idle_pct = 86;
      for (int k = 0; k < 60; k++) send_item(rand_place());
      drain();
      // long receiver hold while the sender keeps offering
      hold_rsp = 1;
      for (int k = 0; k < 4; k++) send_item(rand_place());
      send_idle_pct = 86; recv_idle_pct = 13;
      for (int k = 0; k < 68; k++) send_item(rand_place());
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      for (int k = 0; k < 68; k++) send_item(rand_place());
      drain();
      stim_done = 1;
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected");
            failures++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status); failures++;
            end
            if (rsp_has_overlap !== e.has_ovl) begin
               $error("has_overlap expected %0d actual %0d", e.has_ovl, rsp_has_overlap);
               failures++;
            end
            if (rsp_overlapped_owner !== e.owner) begin
               $error("overlapped_owner expected %0h actual %0h", e.owner,
                      rsp_overlapped_owner);
               failures++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last); failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_interval_overlay_table_core: FAIL");
         $finish;
      end else if (stim_done) begin
         if (failures == 0 && pending_results.size() == 0)
            $display("tb_interval_overlay_table_core: PASS");
         else
            $display("tb_interval_overlay_table_core: FAIL");
         $finish;
      end
   end

endmodule
